>>> rtl/assert_macros.svh
// Assertion macros shared by the timer bank RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication checked on every rising clock edge outside of reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/cptb_pkg.sv
// Types, codes and constants for the cascading prescaled timer bank.
package cptb_pkg;

  localparam int unsigned DivW = 10;

  // Control word bit positions.
  localparam int unsigned CtlCascadeBit = 2;
  localparam int unsigned CtlIrqBit     = 6;
  localparam int unsigned CtlEnableBit  = 7;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_WR_RELOAD  = 3'd1,
    OP_WR_CONTROL = 3'd2,
    OP_RD_COUNTER = 3'd3,
    OP_RD_CONTROL = 3'd4
  } opcode_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [1:0]  timer_index;
    logic [15:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [3:0]  irq_mask;
    logic [3:0]  overflow_mask;
  } out_item_t;

  // Divider bits that must be zero for a timer to count at a given prescale.
  function automatic logic [DivW-1:0] prescale_mask(input logic [1:0] sel);
    logic [DivW-1:0] m;
    case (sel)
      2'd0:    m = 10'h000;
      2'd1:    m = 10'h03F;
      2'd2:    m = 10'h0FF;
      default: m = 10'h3FF;
    endcase
    return m;
  endfunction

endpackage

>>> rtl/cptb_bank.sv
// Timer state, divider and the single-pass update logic for one item.
module cptb_bank import cptb_pkg::*; #(
  parameter int unsigned NUM_TIMERS  = 4,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  output out_item_t result_o
);

  logic [COUNT_WIDTH-1:0] count_q  [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] count_d  [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] reload_q [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] reload_d [NUM_TIMERS];
  logic [15:0]            ctrl_q   [NUM_TIMERS];
  logic [15:0]            ctrl_d   [NUM_TIMERS];
  logic [DivW-1:0]        div_q, div_d;

  logic [NUM_TIMERS-1:0]  ovf_vec, irq_vec;
  logic [NUM_TIMERS+3:0]  ovf_wide, irq_wide;

  always_comb begin
    logic                   below;
    logic                   counts;
    logic                   hit;
    logic [31:0]            wide_data;
    logic [31:0]            wide_cnt;
    logic [COUNT_WIDTH-1:0] one;

    below     = 1'b0;
    counts    = 1'b0;
    hit       = 1'b0;
    wide_cnt  = '0;
    wide_data = 32'(item_i.write_data);
    one       = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
    div_d     = div_q;
    ovf_vec   = '0;
    irq_vec   = '0;
    result_o  = '0;

    if (item_i.opcode == OP_TICK) begin
      div_d = div_q + 1'b1;
    end

    for (int i = 0; i < NUM_TIMERS; i++) begin
      count_d[i]  = count_q[i];
      reload_d[i] = reload_q[i];
      ctrl_d[i]   = ctrl_q[i];
      hit         = int'(item_i.timer_index) == i;
      wide_cnt    = 32'(count_q[i]);

      case (item_i.opcode)
        OP_TICK: begin
          // Cascaded timers see the overflow of the timer below on the same tick.
          counts = 1'b0;
          if (ctrl_q[i][CtlEnableBit]) begin
            if (ctrl_q[i][CtlCascadeBit]) begin
              counts = (i != 0) && below;
            end else begin
              counts = (div_d & prescale_mask(ctrl_q[i][1:0])) == '0;
            end
          end
          ovf_vec[i] = counts && (count_q[i] == '1);
          irq_vec[i] = ovf_vec[i] && ctrl_q[i][CtlIrqBit];
          if (ovf_vec[i]) begin
            count_d[i] = reload_q[i];
          end else if (counts) begin
            count_d[i] = count_q[i] + one;
          end
        end
        OP_WR_RELOAD: begin
          if (hit) begin
            reload_d[i] = wide_data[COUNT_WIDTH-1:0];
            if (!ctrl_q[i][CtlEnableBit]) begin
              count_d[i] = wide_data[COUNT_WIDTH-1:0];
            end
          end
        end
        OP_WR_CONTROL: begin
          if (hit) begin
            ctrl_d[i] = item_i.write_data;
            if (!ctrl_q[i][CtlEnableBit] && item_i.write_data[CtlEnableBit]) begin
              count_d[i] = reload_q[i];
            end
          end
        end
        OP_RD_COUNTER: begin
          if (hit) begin
            result_o.read_data = wide_cnt[15:0];
          end
        end
        OP_RD_CONTROL: begin
          if (hit) begin
            result_o.read_data = ctrl_q[i];
          end
        end
        default: ;
      endcase
      below = ovf_vec[i];
    end

    ovf_wide = {4'b0000, ovf_vec};
    irq_wide = {4'b0000, irq_vec};
    result_o.overflow_mask = ovf_wide[3:0];
    result_o.irq_mask      = irq_wide[3:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q <= '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        count_q[i]  <= '0;
        reload_q[i] <= '0;
        ctrl_q[i]   <= '0;
      end
    end else if (step_i) begin
      div_q <= div_d;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        count_q[i]  <= count_d[i];
        reload_q[i] <= reload_d[i];
        ctrl_q[i]   <= ctrl_d[i];
      end
    end
  end

endmodule

>>> rtl/cascading_prescaled_timer_bank_top.sv
// Top level of the cascading prescaled timer bank: input stage, result stage.
// An accepted item passes through the input register, then the bank update into
// the result register; throughput is one item per cycle while results are taken.
// The rate is set by the single pass of the bank update between the two registers.
// Reset (rst_ni low, asynchronous) clears all counters, reloads, control words
// and the divider, and empties both pipeline registers.
module cascading_prescaled_timer_bank_top import cptb_pkg::*; #(
  parameter int unsigned NUM_TIMERS  = 4,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

`include "assert_macros.svh"

  // Input register: holds one item until the bank can process it.
  logic      in_valid_q;
  in_item_t  in_item_q;

  // Result register: holds one result until the consumer takes it.
  logic      out_valid_q;
  out_item_t out_item_q;

  out_item_t bank_result;
  logic      advance;

  // The bank processes the held item whenever the result register is empty
  // or is being emptied in this same cycle. State updates happen only then,
  // so each item sees exactly what the previous one left behind.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);

  // A new item may enter whenever the input register is empty or its
  // occupant moves on in this cycle; a result left waiting blocks entry only
  // while the input register is also full.
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q <= in_item_i;
    end
  end

  cptb_bank #(
    .NUM_TIMERS  (NUM_TIMERS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_bank (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_item_q),
    .result_o (bank_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= bank_result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // An IRQ is only ever reported for a timer that also overflowed.
  `ASSERT_IMPL(a_irq_implies_ovf, clk_i, rst_ni, out_valid_q, (out_item_q.irq_mask & ~out_item_q.overflow_mask) == 4'b0000, "irq bit without overflow")
  // Read data and overflow reports never come from the same item.
  `ASSERT_IMPL(a_read_no_ovf, clk_i, rst_ni, out_valid_q && (out_item_q.read_data != 16'h0000), out_item_q.overflow_mask == 4'b0000, "read result carries overflow")
  // A held item that cannot advance is still held in the next cycle.
  `ASSERT_NEXT(a_hold_input, clk_i, rst_ni, in_valid_q && !advance, in_valid_q, "input item lost while stalled")
  // Every processed item leaves a result in the result register.
  `ASSERT_NEXT(a_advance_result, clk_i, rst_ni, advance, out_valid_q, "processed item gave no result")

endmodule
